### design/cross_stencil_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cross stencil filter
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef CROSS_STENCIL_FILTER_CORE_ASSERT_SVH
`define CROSS_STENCIL_FILTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// check with reset masking
`define CSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also runs during reset
`define CSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared constants and register codes of the cross stencil filter.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    localparam int LINE_WIDTH_BITS   = 11;
    localparam int FRAME_HEIGHT_BITS = 16;
    localparam int ROW_BITS          = 16;
    localparam int CFG_IDX_BITS      = 3;
    localparam int MIN_DIM           = 3;

    localparam int COEF_CENTER_RST  = 1;
    localparam int COEF_UP_RST      = 2;
    localparam int COEF_DOWN_RST    = 3;
    localparam int COEF_LEFT_RST    = 4;
    localparam int COEF_RIGHT_RST   = 5;
    localparam int LINE_WIDTH_RST   = 1024;
    localparam int FRAME_HEIGHT_RST = 1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_CENTER  = 3'd0,
        CFG_COEF_UP      = 3'd1,
        CFG_COEF_DOWN    = 3'd2,
        CFG_COEF_LEFT    = 3'd3,
        CFG_COEF_RIGHT   = 3'd4,
        CFG_LINE_WIDTH   = 3'd5,
        CFG_FRAME_HEIGHT = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

### design/csf_in_if.sv
// ----------------------------------------------------------------------------
// csf_in_if
// Valid/ready channel carrying one raster sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface csf_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### design/csf_out_if.sv
// ----------------------------------------------------------------------------
// csf_out_if
// Valid/ready channel carrying one filtered interior point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface csf_out_if #(
    parameter int VALUE_W = 35,
    parameter int ROW_W   = 16,
    parameter int COL_W   = 10
);
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] filtered_value;
    logic [ROW_W-1:0]          center_row;
    logic [COL_W-1:0]          center_col;
    logic                      last_of_frame;

    modport source (output valid, output filtered_value, output center_row,
                    output center_col, output last_of_frame, input ready);
    modport sink   (input valid, input filtered_value, input center_row,
                    input center_col, input last_of_frame, output ready);
endinterface

`default_nettype wire

### design/cross_stencil_filter_core.sv
// ----------------------------------------------------------------------------
// cross_stencil_filter_core
// Weighted five-point cross stencil over a raster sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Feed grid samples in raster order on i_sample_ch, one beat per sample.
//   For every interior point one beat leaves on o_result_ch, carrying the
//   weighted sum of centre, up, down, left and right neighbors, the centre's
//   row and column, and a flag on the final interior point of the frame.
//   Border points give no beat. The beat for a centre is triggered by the
//   sample below-right of it.
//   Throughput is one sample per cycle while the receiver does not stall.
//   The accepting edge of the triggering sample loads the line buffer read;
//   the product stage and then the output register with the sum follow.
//   Coefficients and grid size come in on the i_cfg_* write port; write them
//   only while no beat is in flight.
//   Reset clears the position to row 0, column 0, loads the default weights
//   and size, and empties the pipeline. Line buffers are not cleared; the
//   first two rows of a frame fill them before any result reads them.
//   When the receiver stalls, the output register and the product stage
//   hold; samples keep flowing in until the stall reaches the first stage,
//   and points without a result never wait on the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_stencil_filter_core
    import csf_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int VALUE_W    = SAMPLE_BITS + COEF_BITS + 3,
    localparam int CFG_DATA_W = (COEF_BITS > FRAME_HEIGHT_BITS) ? COEF_BITS
                                                                : FRAME_HEIGHT_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    csf_in_if.sink                       i_sample_ch,
    csf_out_if.source                    o_result_ch
);

    `include "cross_stencil_filter_core_assert.svh"

    // width of grid size compares: holds line_width and MAX_WIDTH
    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int DIM_W   = (MW_BITS > LINE_WIDTH_BITS) ? MW_BITS : LINE_WIDTH_BITS;
    localparam int PROD_W  = SAMPLE_BITS + COEF_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_BITS-1:0]   r_coef_center, r_coef_up, r_coef_down;
    logic signed [COEF_BITS-1:0]   r_coef_left, r_coef_right;
    logic [LINE_WIDTH_BITS-1:0]    r_line_width;
    logic [FRAME_HEIGHT_BITS-1:0]  r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_center  <= COEF_BITS'(COEF_CENTER_RST);
            r_coef_up      <= COEF_BITS'(COEF_UP_RST);
            r_coef_down    <= COEF_BITS'(COEF_DOWN_RST);
            r_coef_left    <= COEF_BITS'(COEF_LEFT_RST);
            r_coef_right   <= COEF_BITS'(COEF_RIGHT_RST);
            r_line_width   <= LINE_WIDTH_BITS'(LINE_WIDTH_RST);
            r_frame_height <= FRAME_HEIGHT_BITS'(FRAME_HEIGHT_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_CENTER:  r_coef_center  <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_UP:      r_coef_up      <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_DOWN:    r_coef_down    <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_LEFT:    r_coef_left    <= i_cfg_data[COEF_BITS-1:0];
                CFG_COEF_RIGHT:   r_coef_right   <= i_cfg_data[COEF_BITS-1:0];
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LINE_WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the grid size to the supported range.
    logic [DIM_W-1:0]             lw_ext;
    logic [DIM_W-1:0]             eff_w;
    logic [FRAME_HEIGHT_BITS-1:0] eff_h;

    assign lw_ext = DIM_W'(r_line_width);
    assign eff_w  = (lw_ext < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM)   :
                    (lw_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : lw_ext;
    assign eff_h  = (r_frame_height < FRAME_HEIGHT_BITS'(MIN_DIM))
                    ? FRAME_HEIGHT_BITS'(MIN_DIM) : r_frame_height;

    // ------------------------------------------------------------------
    // Handshake across the three stages
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic n_s1_valid, n_s2_valid, n_out_valid;
    logic r_s1_emit;
    logic out_free, s2_adv, s2_free, s1_adv, in_ready, accept;

    assign out_free = !r_out_valid || o_result_ch.ready;
    assign s2_adv   = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || s2_adv;
    // a point without a result leaves stage 1 regardless of the receiver
    assign s1_adv   = r_s1_valid && (!r_s1_emit || s2_free);
    assign in_ready = !r_s1_valid || s1_adv;
    assign accept   = i_sample_ch.valid && in_ready;

    assign i_sample_ch.ready = in_ready;

    always_comb begin
        n_s1_valid  = accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
        n_s2_valid  = (s1_adv && r_s1_emit) ? 1'b1 : (s2_adv ? 1'b0 : r_s2_valid);
        n_out_valid = s2_adv ? 1'b1 : (o_result_ch.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Grid position of the next sample
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [DIM_W-1:0]    col_ext, col_inc;
    logic [ROW_BITS:0]   row_inc;
    logic                row_end, frame_end;

    assign col_ext   = DIM_W'(r_col);
    assign col_inc   = col_ext + DIM_W'(1);
    assign row_inc   = {1'b0, r_row} + (ROW_BITS+1)'(1);
    assign row_end   = col_inc >= eff_w;
    assign frame_end = row_inc >= {1'b0, eff_h};

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : row_inc[ROW_BITS-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line buffer read and item capture on accept
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] mem_above [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] mem_two   [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] r_above_rd, r_two_rd;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [COL_W-1:0]       r_s1_addr;
    logic [ROW_BITS-1:0]    r_s1_row;
    logic [COL_W-1:0]       r_s1_col;
    logic                   r_s1_last;
    logic                   is_interior, is_last;

    assign is_interior = (r_row >= ROW_BITS'(2)) && (r_col >= COL_W'(2)) &&
                         (col_ext < eff_w) && (r_row < eff_h);
    assign is_last     = (row_inc[ROW_BITS-1:0] == eff_h) && (col_inc == eff_w);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above_rd  <= mem_above[r_col];
            r_two_rd    <= mem_two[r_col];
            r_s1_sample <= i_sample_ch.sample;
            r_s1_addr   <= r_col;
            r_s1_row    <= r_row - ROW_BITS'(1);
            r_s1_col    <= r_col - COL_W'(1);
            r_s1_emit   <= is_interior;
            r_s1_last   <= is_last;
        end
    end

    // Shift the buffers as the item leaves stage 1; a later read of the same
    // column is at least one row behind, so it always sees this write.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem_two[r_s1_addr]   <= r_above_rd;
            mem_above[r_s1_addr] <= r_s1_sample;
        end
    end

    // Window: up is row r-2 at c-1, left and centre row r-1 at c-2 and c-1,
    // down row r at c-1. Right is the line buffer word just read.
    logic [SAMPLE_BITS-1:0] r_tap_up, r_tap_left, r_tap_center, r_tap_down;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_tap_up     <= r_two_rd;
            r_tap_left   <= r_tap_center;
            r_tap_center <= r_above_rd;
            r_tap_down   <= r_s1_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: five products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] p_center, p_up, p_down, p_left, p_right;

    assign p_center = PROD_W'(signed'({1'b0, r_tap_center})) * PROD_W'(r_coef_center);
    assign p_up     = PROD_W'(signed'({1'b0, r_tap_up}))     * PROD_W'(r_coef_up);
    assign p_down   = PROD_W'(signed'({1'b0, r_tap_down}))   * PROD_W'(r_coef_down);
    assign p_left   = PROD_W'(signed'({1'b0, r_tap_left}))   * PROD_W'(r_coef_left);
    assign p_right  = PROD_W'(signed'({1'b0, r_above_rd}))   * PROD_W'(r_coef_right);

    logic signed [PROD_W-1:0] r_p_center, r_p_up, r_p_down, r_p_left, r_p_right;
    logic [ROW_BITS-1:0]      r_s2_row;
    logic [COL_W-1:0]         r_s2_col;
    logic                     r_s2_last;

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_p_center <= p_center;
            r_p_up     <= p_up;
            r_p_down   <= p_down;
            r_p_left   <= p_left;
            r_p_right  <= p_right;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_s2_last  <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Output register: sum of products
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] sum;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [ROW_BITS-1:0]       r_out_row;
    logic [COL_W-1:0]          r_out_col;
    logic                      r_out_last;

    assign sum = VALUE_W'(r_p_center) + VALUE_W'(r_p_up) + VALUE_W'(r_p_down) +
                 VALUE_W'(r_p_left) + VALUE_W'(r_p_right);

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_value <= sum;
            r_out_row   <= r_s2_row;
            r_out_col   <= r_s2_col;
            r_out_last  <= r_s2_last;
        end
    end

    assign o_result_ch.valid          = r_out_valid;
    assign o_result_ch.filtered_value = r_out_value;
    assign o_result_ch.center_row     = r_out_row;
    assign o_result_ch.center_col     = r_out_col;
    assign o_result_ch.last_of_frame  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CSF_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !r_s1_valid && !r_s2_valid && !r_out_valid,
        "pipeline not empty after reset")
    `CSF_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, accept |=> r_s1_valid,
        "accepted beat lost before stage 1")
    `CSF_ASSERT(a_s2_holds_on_stall, i_clk, i_rst_n,
        r_s2_valid && !out_free |=> r_s2_valid, "product stage dropped on stall")
    `CSF_ASSERT(a_result_interior, i_clk, i_rst_n,
        r_out_valid |-> r_out_row != '0 && r_out_col != '0,
        "result for a border point")

endmodule

`default_nettype wire

### bench/cross_stencil_filter_core_tb.sv
// ----------------------------------------------------------------------------
// cross_stencil_filter_core_tb
// Self-checking bench for the five-point cross stencil core. A scripted
// opening covers the size clamps, frame wrap and the value extremes; random
// phases with changing weights and grid sizes follow. Every result beat is
// compared with a behavioral stencil kept inside the bench.
// ----------------------------------------------------------------------------
module cross_stencil_filter_core_tb import csf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W      = SAMPLE_BITS_DEF + COEF_BITS_DEF + 3;
    localparam int COL_W        = $clog2(MAX_WIDTH_DEF);
    localparam int CFG_W        = (COEF_BITS_DEF > FRAME_HEIGHT_BITS) ? COEF_BITS_DEF
                                                                      : FRAME_HEIGHT_BITS;
    localparam int PIPE_LATENCY = 2;     // accepting edge to result beat
    localparam int QUIET_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int RANDOM_ITEMS = 400;

    // One filtered interior point as it leaves the core.
    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic [ROW_BITS-1:0]        row;
        logic [COL_W-1:0]           col;
        logic                       last;
    } t_stencil_point;

    typedef enum bit {STEP_CFG, STEP_SAMPLE} t_step_kind;

    // One row of the opening script: a register write or a sample beat,
    // with the result typed in where it is obvious.
    typedef struct {
        t_step_kind         kind;
        t_cfg_idx           reg_idx;
        logic [CFG_W-1:0]   data;
        bit                 typed;
        t_stencil_point     point;
    } t_script_step;

    typedef enum int {RX_OPEN, RX_COIN, RX_HOLDS} t_rx_mode;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    t_cfg_idx                   i_cfg_idx;
    logic [CFG_W-1:0]           i_cfg_data;

    csf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_ch ();
    csf_out_if #(.VALUE_W(VALUE_W), .ROW_W(ROW_BITS), .COL_W(COL_W)) result_ch ();

    cross_stencil_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch)
    );

    // ------------------------------------------------------------------------
    // Behavioral stencil: weights, grid size, line buffers, window, position.
    // Line buffers start at zero here; the stimulus never lets a result read
    // an entry that the core has not written.
    // ------------------------------------------------------------------------
    logic signed [COEF_BITS_DEF-1:0] wt_center  = COEF_BITS_DEF'(COEF_CENTER_RST);
    logic signed [COEF_BITS_DEF-1:0] wt_up      = COEF_BITS_DEF'(COEF_UP_RST);
    logic signed [COEF_BITS_DEF-1:0] wt_down    = COEF_BITS_DEF'(COEF_DOWN_RST);
    logic signed [COEF_BITS_DEF-1:0] wt_left    = COEF_BITS_DEF'(COEF_LEFT_RST);
    logic signed [COEF_BITS_DEF-1:0] wt_right   = COEF_BITS_DEF'(COEF_RIGHT_RST);
    logic [LINE_WIDTH_BITS-1:0]      width_reg  = LINE_WIDTH_BITS'(LINE_WIDTH_RST);
    logic [FRAME_HEIGHT_BITS-1:0]    height_reg = FRAME_HEIGHT_BITS'(FRAME_HEIGHT_RST);

    bit [SAMPLE_BITS_DEF-1:0] above_line     [MAX_WIDTH_DEF];
    bit [SAMPLE_BITS_DEF-1:0] two_above_line [MAX_WIDTH_DEF];
    // [0],[1]: row r-2 at c-2, c-1; [2],[3]: row r-1; [4],[5]: row r
    bit [SAMPLE_BITS_DEF-1:0] taps [6];
    int unsigned              row_pos = 0;
    int unsigned              col_pos = 0;

    t_stencil_point pending_points[$];
    t_script_step   script[$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  items_sent     = 0;
    int  burst_left     = 0;
    int  gap_limit      = 0;
    bit  cfg_open       = 0;

    // Clamp the size registers the way the core does.
    function automatic int eff_width(input logic [LINE_WIDTH_BITS-1:0] w);
        if (w < MIN_DIM) return MIN_DIM;
        if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(w);
    endfunction

    function automatic int eff_height(input logic [FRAME_HEIGHT_BITS-1:0] h);
        return (h < MIN_DIM) ? MIN_DIM : int'(h);
    endfunction

    // Advance the stencil by one sample; return 1 with the point when the
    // sample completes the cross of an interior centre.
    function automatic bit stencil_step(input logic [SAMPLE_BITS_DEF-1:0] s,
                                        output t_stencil_point pt);
        int unsigned              w;
        int unsigned              h;
        int unsigned              r;
        int unsigned              c;
        int unsigned              idx;
        bit [SAMPLE_BITS_DEF-1:0] above_now;
        bit [SAMPLE_BITS_DEF-1:0] two_now;
        longint                   acc;
        bit                       hit;
        w         = eff_width(width_reg);
        h         = eff_height(height_reg);
        r         = row_pos;
        c         = col_pos;
        idx       = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
        above_now = above_line[idx];
        two_now   = two_above_line[idx];
        hit       = 1'b0;
        pt        = '0;

        // The centre sits one up and one left of the sample now arriving.
        if (r >= 2 && c >= 2 && c < w && r < h) begin
            acc = longint'(wt_center) * longint'(taps[3])
                + longint'(wt_up)     * longint'(taps[1])
                + longint'(wt_down)   * longint'(taps[5])
                + longint'(wt_left)   * longint'(taps[2])
                + longint'(wt_right)  * longint'(above_now);
            pt.value = acc[VALUE_W-1:0];
            pt.row   = ROW_BITS'(r - 1);
            pt.col   = COL_W'(c - 1);
            pt.last  = (r == h - 1) && (c == w - 1);
            hit      = 1'b1;
        end

        taps[0] = taps[1]; taps[1] = two_now;
        taps[2] = taps[3]; taps[3] = above_now;
        taps[4] = taps[5]; taps[5] = s;

        two_above_line[idx] = above_now;
        above_line[idx]     = s;

        // Wrap the row at the width, and the frame at the height.
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            col_pos = c + 1;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        script.push_back('{STEP_CFG, idx, data, 1'b0, '0});
    endfunction

    function automatic void add_sample(input logic [SAMPLE_BITS_DEF-1:0] data,
                                       input bit typed = 1'b0,
                                       input t_stencil_point pt = '0);
        script.push_back('{STEP_SAMPLE, CFG_COEF_CENTER, CFG_W'(data), typed, pt});
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_W'($urandom_range(0, MIN_DIM - 1));
            1: return CFG_W'($urandom_range(13, 40));
            default: return CFG_W'($urandom_range(MIN_DIM, 12));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        case ($urandom_range(0, 11))
            0: return CFG_W'($urandom_range(0, MIN_DIM - 1));
            1: return 16'hFFFF;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(MIN_DIM, 8));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_BITS_DEF'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Write one register and mirror it. Keep the write enable high so that a
    // following write does not lower and raise it in the same step.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_COEF_CENTER:  wt_center  = data[COEF_BITS_DEF-1:0];
            CFG_COEF_UP:      wt_up      = data[COEF_BITS_DEF-1:0];
            CFG_COEF_DOWN:    wt_down    = data[COEF_BITS_DEF-1:0];
            CFG_COEF_LEFT:    wt_left    = data[COEF_BITS_DEF-1:0];
            CFG_COEF_RIGHT:   wt_right   = data[COEF_BITS_DEF-1:0];
            CFG_LINE_WIDTH:   width_reg  = data[LINE_WIDTH_BITS-1:0];
            CFG_FRAME_HEIGHT: height_reg = data[FRAME_HEIGHT_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_open = 1'b1;
    endtask

    task automatic close_cfg();
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    // Drop valid, wait for every expected beat, then let the pipeline empty
    // of border points too before any register is touched.
    task automatic settle_pipeline();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Send one sample beat inside the current burst; open a gap first when
    // the burst is used up. Predict on the accepting edge.
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] v,
                               input bit typed = 1'b0,
                               input t_stencil_point typed_pt = '0);
        t_stencil_point pt;
        bit             hit;
        int             gap;
        close_cfg();
        if (burst_left == 0) begin
            gap = (gap_limit > 0) ? $urandom_range(0, gap_limit) : 0;
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= v;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        items_sent++;
        hit = stencil_step(v, pt);
        if (typed)
            pending_points.push_back(typed_pt);
        else if (hit)
            pending_points.push_back(pt);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: switch between always ready, coin-flip ready and long holds.
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (mode)
                RX_OPEN: result_ch.ready <= 1'b1;
                RX_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        result_ch.ready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        hold_left = $urandom_range(1, 12);
                        result_ch.ready <= 1'b0;
                    end else begin
                        result_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted beat with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stencil_point want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected beat row %0d col %0d value %0d",
                                          result_ch.center_row, result_ch.center_col,
                                          result_ch.filtered_value));
            end else begin
                want = pending_points.pop_front();
                if (result_ch.filtered_value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d (row %0d col %0d)",
                                              result_ch.filtered_value, want.value,
                                              want.row, want.col));
                if (result_ch.center_row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d",
                                              result_ch.center_row, want.row));
                if (result_ch.center_col !== want.col)
                    report_mismatch($sformatf("col %0d, want %0d",
                                              result_ch.center_col, want.col));
                if (result_ch.last_of_frame !== want.last)
                    report_mismatch($sformatf("last flag %b, want %b at row %0d col %0d",
                                              result_ch.last_of_frame, want.last,
                                              want.row, want.col));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no beat moves on either side for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] val;
        int               n;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_COEF_CENTER;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;

        // Build the opening script: three 3x3 frames back to back, one
        // interior point each, which is also the last of its frame.
        // Width 0 and height 2 must clamp to 3; all-zero samples give zero.
        add_cfg(CFG_LINE_WIDTH, CFG_W'(0));
        add_cfg(CFG_FRAME_HEIGHT, CFG_W'(2));
        repeat (8) add_sample('0);
        add_sample('0, 1'b1, '{35'sd0, 16'd1, 10'd1, 1'b1});

        // Most negative weights on full-scale samples: lowest possible sum.
        for (int k = CFG_COEF_CENTER; k <= CFG_COEF_RIGHT; k++)
            add_cfg(t_cfg_idx'(k), 16'h8000);
        repeat (8) add_sample('1);
        add_sample('1, 1'b1, '{-35'sd10737254400, 16'd1, 10'd1, 1'b1});

        // Most positive weights on full-scale samples: highest possible sum.
        for (int k = CFG_COEF_CENTER; k <= CFG_COEF_RIGHT; k++)
            add_cfg(t_cfg_idx'(k), 16'h7FFF);
        add_cfg(CFG_LINE_WIDTH, CFG_W'(MIN_DIM));
        add_cfg(CFG_FRAME_HEIGHT, CFG_W'(MIN_DIM));
        repeat (8) add_sample('1);
        add_sample('1, 1'b1, '{35'sd10736926725, 16'd1, 10'd1, 1'b1});

        // Hold reset, then release it once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_limit = 2;
        foreach (script[i]) begin
            if (script[i].kind == STEP_CFG) begin
                if (i == 0 || script[i-1].kind != STEP_CFG)
                    settle_pipeline();
                write_reg(script[i].reg_idx, script[i].data);
            end else begin
                send_sample(script[i].data[SAMPLE_BITS_DEF-1:0], script[i].typed,
                            script[i].point);
            end
        end

        // Wide rows: the frame ends at row 0, so growing the width is safe.
        // Run two full rows plus part of the third to fill both line buffers.
        settle_pipeline();
        write_reg(CFG_LINE_WIDTH, $urandom_range(0, 1) ? 16'd2047 : 16'd1024);
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(MIN_DIM));
        for (int k = CFG_COEF_CENTER; k <= CFG_COEF_RIGHT; k++)
            write_reg(t_cfg_idx'(k), pick_coef());
        gap_limit = 0;
        n = 2 * MAX_WIDTH_DEF + $urandom_range(20, 200);
        repeat (n) send_sample(pick_sample());

        // Random phases: new weights and sizes wherever the position stands,
        // so shrinking mid-row and mid-frame is exercised. Grow the width
        // only at row 0, where rows 0 and 1 refill the line buffers before
        // any result reads them.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle_pipeline();
            for (int k = CFG_COEF_CENTER; k <= CFG_FRAME_HEIGHT; k++) begin
                if ($urandom_range(0, 1)) begin
                    case (t_cfg_idx'(k))
                        CFG_LINE_WIDTH: begin
                            val = pick_width();
                            if (row_pos == 0 ||
                                eff_width(val[LINE_WIDTH_BITS-1:0]) <= eff_width(width_reg))
                                write_reg(CFG_LINE_WIDTH, val);
                        end
                        CFG_FRAME_HEIGHT: write_reg(CFG_FRAME_HEIGHT, pick_height());
                        default:          write_reg(t_cfg_idx'(k), pick_coef());
                    endcase
                end
            end
            gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            n = $urandom_range(20, 160);
            repeat (n) send_sample(pick_sample());
        end

        // Drain and give stray beats a chance to show up.
        close_cfg();
        settle_pipeline();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/csf_pkg.sv
design/csf_in_if.sv
design/csf_out_if.sv
design/cross_stencil_filter_core.sv
bench/cross_stencil_filter_core_tb.sv
